// ===== rtl/core/ssc_pkg.sv =====
// shared types, constants and rate helpers for the sodium channel population stepper
package ssc_pkg;

  localparam int DEF_MAX_CHANNELS = 4096;
  localparam int DEF_DRAW_BITS    = 16;
  localparam int NSTATES          = 8;
  localparam int PROB_W           = 16;
  localparam int RATE_IN_W        = 16;
  localparam int RATE_W           = 18;
  localparam int CFG_W            = 64;
  localparam int CFG_INDEX_W      = 3;
  localparam int QUEUE_DEPTH      = 4;
  localparam int TOTAL_RESET      = 4096;

  // gating states, m count in the low two bits, h gate in bit 2
  localparam logic [2:0] M0H0 = 3'd0;
  localparam logic [2:0] M1H0 = 3'd1;
  localparam logic [2:0] M2H0 = 3'd2;
  localparam logic [2:0] M3H0 = 3'd3;
  localparam logic [2:0] M0H1 = 3'd4;
  localparam logic [2:0] M1H1 = 3'd5;
  localparam logic [2:0] M2H1 = 3'd6;
  localparam logic [2:0] M3H1 = 3'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ESC_H0,
    REG_ESC_H1,
    REG_RATE_M_OPEN,
    REG_RATE_H_OPEN,
    REG_RATE_M_CLOSE,
    REG_RATE_H_CLOSE,
    REG_CHANNEL_TOTAL
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0]     esc_h0;
    logic [CFG_W-1:0]     esc_h1;
    logic [RATE_IN_W-1:0] am;
    logic [RATE_IN_W-1:0] ah;
    logic [RATE_IN_W-1:0] bm;
    logic [RATE_IN_W-1:0] bh;
  } cfg_t;

  typedef struct packed {
    logic [RATE_W-1:0] gamma;
    logic [RATE_W-1:0] p1;
    logic [RATE_W-1:0] p2;
  } sums_t;

  // one classified trial on its way to the count update
  typedef struct packed {
    logic       move;
    logic [2:0] src;
    logic [2:0] dst;
    logic       last;
  } op_t;

  function automatic logic [RATE_W-1:0] times3(logic [1:0] k, logic [RATE_IN_W-1:0] v);
    logic [RATE_W-1:0] x;
    x = RATE_W'(v);
    case (k)
      2'd0:    times3 = '0;
      2'd1:    times3 = x;
      2'd2:    times3 = x << 1;
      default: times3 = x + (x << 1);
    endcase
  endfunction

  // total rate and the two partial sums for a source state
  function automatic sums_t rate_sums(logic [2:0] s, cfg_t c);
    logic [1:0]        mk;
    logic [RATE_W-1:0] hx;
    logic [RATE_W-1:0] am_part;
    logic [RATE_W-1:0] bm_part;
    sums_t             r;
    mk      = s[1:0];
    hx      = s[2] ? RATE_W'(c.bh) : RATE_W'(c.ah);
    am_part = times3(2'd3 - mk, c.am);
    bm_part = times3(mk, c.bm);
    r.gamma = am_part + hx + bm_part;
    r.p1    = (mk == 2'd3) ? hx : am_part;
    r.p2    = (mk == 2'd3) ? r.gamma : am_part + hx;
    return r;
  endfunction

  // destinations: [0] first branch, [1] second branch, [2] otherwise
  function automatic logic [2:0][2:0] dest_of(logic [2:0] s);
    unique case (s)
      M0H0: dest_of = {M0H1, M0H1, M1H0};
      M1H0: dest_of = {M0H0, M1H1, M2H0};
      M2H0: dest_of = {M1H0, M2H1, M3H0};
      M3H0: dest_of = {M2H0, M2H0, M3H1};
      M0H1: dest_of = {M0H0, M0H0, M1H1};
      M1H1: dest_of = {M0H1, M1H0, M2H1};
      M2H1: dest_of = {M1H1, M2H0, M3H1};
      M3H1: dest_of = {M2H1, M2H1, M3H0};
    endcase
  endfunction

endpackage

// ===== rtl/core/ssc_queue.sv =====
// small fifo of classified trials between the front and the back
module ssc_queue #(
  parameter int DEPTH = ssc_pkg::QUEUE_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int QCW  = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ssc_pkg::op_t   wdata,
  input  logic           rd,
  output ssc_pkg::op_t   rdata,
  output logic           not_empty,
  output logic [QCW-1:0] count
);
  import ssc_pkg::*;

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign rdata     = mem[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + QCW'(wr) - QCW'(rd);
    end
  end

endmodule

// ===== rtl/core/ssc_front.sv =====
// trial sequencer, escape test and branch selection pipeline
module ssc_front #(
  parameter int MAX_CHANNELS = ssc_pkg::DEF_MAX_CHANNELS,
  parameter int DRAW_BITS    = ssc_pkg::DEF_DRAW_BITS,
  parameter int QUEUE_DEPTH  = ssc_pkg::QUEUE_DEPTH,
  localparam int CW          = $clog2(MAX_CHANNELS + 1),
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DRAW_BITS-1:0] trial_draw,
  input  logic [DRAW_BITS-1:0] branch_draw,
  output logic                 ready,
  input  ssc_pkg::cfg_t        cfg,
  input  logic                 seed_req,
  input  logic                 restart,
  input  logic [CW-1:0]        snapshot [ssc_pkg::NSTATES],
  input  logic [QCW-1:0]       q_count,
  output logic                 q_push,
  output ssc_pkg::op_t         q_data
);
  import ssc_pkg::*;

  localparam int EW = DRAW_BITS + PROB_W;
  localparam int PW = DRAW_BITS + RATE_W;

  logic [2:0]    cur;
  logic [CW-1:0] left;
  logic          waiting;
  logic          seed;

  logic          seek_go;
  logic          acc;
  logic [QCW:0]  occ;
  logic [3:0]    start;
  logic          hit;
  logic [2:0]    found;
  logic [CW-1:0] found_left;
  logic [CW-1:0] left_dec;
  logic          is_last;

  logic [CFG_W-1:0]  esc_word;
  logic [PROB_W-1:0] prob;
  logic              escape;

  logic                 v1;
  logic [2:0]           s1;
  logic                 esc1;
  logic [DRAW_BITS-1:0] br1;
  sums_t                sums1;
  logic                 last1;

  logic              v2;
  logic [2:0]        s2;
  logic              esc2;
  logic [PW-1:0]     prod2;
  logic [RATE_W-1:0] p1_2;
  logic [RATE_W-1:0] p2_2;
  logic              last2;

  logic [2:0][2:0] dests;
  logic [2:0]      dst;

  assign seek_go = seed | restart;
  assign occ     = {1'b0, q_count} + (QCW + 1)'(v1) + (QCW + 1)'(v2);
  assign ready   = !waiting && !seek_go && (occ < (QCW + 1)'(QUEUE_DEPTH));
  assign acc     = push && ready;

  // first nonempty population at or after start
  assign start = seek_go ? 4'd0 : {1'b0, cur} + 4'd1;

  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int k = NSTATES - 1; k >= 0; k--) begin
      if ((4'(k) >= start) && (snapshot[k] != '0)) begin
        hit   = 1'b1;
        found = 3'(k);
      end
    end
  end

  assign found_left = hit ? snapshot[found] : '0;
  assign left_dec   = (left == '0) ? '0 : left - CW'(1);
  assign is_last    = (left_dec == '0) && !hit;

  assign esc_word = cur[2] ? cfg.esc_h1 : cfg.esc_h0;
  assign prob     = esc_word[PROB_W * cur[1:0] +: PROB_W];
  assign escape   = (left != '0) &&
                    ({trial_draw, {PROB_W{1'b0}}} <= EW'({prob, {DRAW_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      left    <= '0;
      waiting <= 1'b0;
      seed    <= 1'b1;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      if (seek_go) begin
        cur     <= hit ? found : '0;
        left    <= found_left;
        waiting <= 1'b0;
      end else if (acc) begin
        if (left_dec != '0) begin
          left <= left_dec;
        end else if (hit) begin
          cur  <= found;
          left <= found_left;
        end else begin
          left    <= '0;
          waiting <= 1'b1;
        end
      end
      // a refill asks for a fresh search on the next cycle
      seed <= seed_req;
      v1   <= acc;
      v2   <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1    <= cur;
      esc1  <= escape;
      br1   <= branch_draw;
      sums1 <= rate_sums(cur, cfg);
      last1 <= is_last;
    end
    s2    <= s1;
    esc2  <= esc1;
    prod2 <= PW'(br1) * PW'(sums1.gamma);
    p1_2  <= sums1.p1;
    p2_2  <= sums1.p2;
    last2 <= last1;
  end

  assign dests = dest_of(s2);

  always_comb begin
    if (prod2 <= PW'({p1_2, {DRAW_BITS{1'b0}}})) begin
      dst = dests[0];
    end else if (prod2 <= PW'({p2_2, {DRAW_BITS{1'b0}}})) begin
      dst = dests[1];
    end else begin
      dst = dests[2];
    end
  end

  assign q_push      = v2;
  assign q_data.move = esc2;
  assign q_data.src  = s2;
  assign q_data.dst  = dst;
  assign q_data.last = last2;

endmodule

// ===== rtl/core/ssc_back.sv =====
// population counters, sweep snapshot and result register
module ssc_back #(
  parameter int MAX_CHANNELS = ssc_pkg::DEF_MAX_CHANNELS,
  localparam int CW          = $clog2(MAX_CHANNELS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fill_req,
  input  logic [CW-1:0] fill_value,
  input  logic          q_valid,
  input  ssc_pkg::op_t  q_head,
  output logic          q_pop,
  input  logic          pop,
  output logic          out_valid,
  output logic [CW-1:0] result [ssc_pkg::NSTATES],
  output logic [CW-1:0] snapshot [ssc_pkg::NSTATES],
  output logic          restart
);
  import ssc_pkg::*;

  localparam logic [CW-1:0] FILL_RESET =
    CW'((TOTAL_RESET > MAX_CHANNELS) ? MAX_CHANNELS : TOTAL_RESET);

  logic [CW-1:0] counts     [NSTATES];
  logic [CW-1:0] counts_upd [NSTATES];
  logic          mv;
  logic          finish;

  assign mv     = q_head.move && (counts[q_head.src] != '0);
  assign q_pop  = q_valid && (!q_head.last || !out_valid || pop);
  assign finish = q_pop && q_head.last;

  always_comb begin
    for (int k = 0; k < NSTATES; k++) begin
      counts_upd[k] = counts[k] - CW'(mv && (q_head.src == 3'(k)))
                                + CW'(mv && (q_head.dst == 3'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTATES; k++) begin
        counts[k]   <= (k == 0) ? FILL_RESET : '0;
        snapshot[k] <= (k == 0) ? FILL_RESET : '0;
      end
      out_valid <= 1'b0;
      restart   <= 1'b0;
    end else begin
      // sweep end raises the result and restarts the front next cycle
      restart   <= finish && !fill_req;
      out_valid <= (finish && !fill_req) || (out_valid && !pop);
      if (fill_req) begin
        for (int k = 0; k < NSTATES; k++) begin
          counts[k]   <= (k == 0) ? fill_value : '0;
          snapshot[k] <= (k == 0) ? fill_value : '0;
        end
      end else if (q_pop) begin
        counts <= counts_upd;
        if (q_head.last) begin
          snapshot <= counts_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= counts_upd;
    end
  end

endmodule

// ===== rtl/core/stochastic_sodium_channel_step.sv =====
// top level of the stochastic eight-state sodium channel population stepper
//
// keeps the number of channels in each of the eight m/h gating states and runs
// one channel trial per pushed request. each request carries trial_draw, tested
// against the escape probability of the channel's current state, and branch_draw,
// which picks the neighbour state by comparing branch_draw times the total rate
// against the partial rate sums. trials walk the sweep snapshot in state order,
// m0h0 first. after the last trial of a sweep the eight counts appear on the
// result side and the next sweep begins from the new counts. throughput is one
// request per clock inside a sweep while the queue has room; the front (escape
// test, multiply, branch compare) and the back (count update) are split by a
// four-entry queue. the next sweep's snapshot only exists once the back has
// retired the last trial, so full stays high after that trial until the back
// has retired it and restarted the front. full is also high after reset or a
// channel_total write while the first population is located. a result that is
// not popped holds the back at the next sweep end; the front keeps accepting
// until the queue fills. configuration writes belong in idle periods.
module stochastic_sodium_channel_step #(
  parameter int MAX_CHANNELS = ssc_pkg::DEF_MAX_CHANNELS,
  parameter int DRAW_BITS    = ssc_pkg::DEF_DRAW_BITS,
  localparam int CW          = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  // trial requests
  input  logic                            push,
  output logic                            full,
  input  logic [DRAW_BITS-1:0]            trial_draw,
  input  logic [DRAW_BITS-1:0]            branch_draw,
  // sweep results
  output logic                            empty,
  input  logic                            pop,
  output logic [CW-1:0]                   count_m0h0,
  output logic [CW-1:0]                   count_m1h0,
  output logic [CW-1:0]                   count_m2h0,
  output logic [CW-1:0]                   count_m3h0,
  output logic [CW-1:0]                   count_m0h1,
  output logic [CW-1:0]                   count_m1h1,
  output logic [CW-1:0]                   count_m2h1,
  output logic [CW-1:0]                   count_m3h1,
  // register writes
  input  logic                            cfg_write,
  input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssc_pkg::CFG_W-1:0]       cfg_data
);
  import ssc_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHANNELS);

  cfg_t          cfg;
  logic          total_write;
  logic [CW-1:0] total_raw;
  logic [CW-1:0] total_clamped;

  logic           ready;
  logic           restart;
  logic [CW-1:0]  snapshot [NSTATES];
  logic [CW-1:0]  result   [NSTATES];
  logic           out_valid;

  logic           q_push;
  op_t            q_wdata;
  op_t            q_head;
  logic           q_pop;
  logic           q_valid;
  logic [QCW-1:0] q_count;

  // register file; channel_total lives only in the counters it refills
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ESC_H0:       cfg.esc_h0 <= cfg_data;
        REG_ESC_H1:       cfg.esc_h1 <= cfg_data;
        REG_RATE_M_OPEN:  cfg.am     <= cfg_data[RATE_IN_W-1:0];
        REG_RATE_H_OPEN:  cfg.ah     <= cfg_data[RATE_IN_W-1:0];
        REG_RATE_M_CLOSE: cfg.bm     <= cfg_data[RATE_IN_W-1:0];
        REG_RATE_H_CLOSE: cfg.bh     <= cfg_data[RATE_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // the low CW bits of channel_total are saturated into 1..max and refill m0h0
  assign total_write   = cfg_write && (cfg_index == REG_CHANNEL_TOTAL);
  assign total_raw     = cfg_data[CW-1:0];
  assign total_clamped = (total_raw == '0)  ? CW'(1) :
                         (total_raw > MAX_C) ? MAX_C  : total_raw;

  assign full  = !ready;
  assign empty = !out_valid;

  ssc_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .DRAW_BITS    (DRAW_BITS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .trial_draw  (trial_draw),
    .branch_draw (branch_draw),
    .ready       (ready),
    .cfg         (cfg),
    .seed_req    (total_write),
    .restart     (restart),
    .snapshot    (snapshot),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  ssc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_push),
    .wdata     (q_wdata),
    .rd        (q_pop),
    .rdata     (q_head),
    .not_empty (q_valid),
    .count     (q_count)
  );

  ssc_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .fill_req   (total_write),
    .fill_value (total_clamped),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .result     (result),
    .snapshot   (snapshot),
    .restart    (restart)
  );

  assign count_m0h0 = result[M0H0];
  assign count_m1h0 = result[M1H0];
  assign count_m2h0 = result[M2H0];
  assign count_m3h0 = result[M3H0];
  assign count_m0h1 = result[M0H1];
  assign count_m1h1 = result[M1H1];
  assign count_m2h1 = result[M2H1];
  assign count_m3h1 = result[M3H1];

endmodule

// ===== rtl/core/ssc_checker.sv =====
// port-level checks for the sodium channel population stepper
module ssc_checker #(
  parameter int MAX_CHANNELS = ssc_pkg::DEF_MAX_CHANNELS,
  localparam int CW          = $clog2(MAX_CHANNELS + 1)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic [CW-1:0]                   count_m0h0,
  input logic [CW-1:0]                   count_m1h0,
  input logic [CW-1:0]                   count_m2h0,
  input logic [CW-1:0]                   count_m3h0,
  input logic [CW-1:0]                   count_m0h1,
  input logic [CW-1:0]                   count_m1h1,
  input logic [CW-1:0]                   count_m2h1,
  input logic [CW-1:0]                   count_m3h1,
  input logic                            cfg_write,
  input logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index
);
  import ssc_pkg::*;

  localparam int SW = CW + 3;

  logic [SW-1:0] count_sum;

  assign count_sum = SW'(count_m0h0) + SW'(count_m1h0) + SW'(count_m2h0) + SW'(count_m3h0)
                   + SW'(count_m0h1) + SW'(count_m1h1) + SW'(count_m2h1) + SW'(count_m3h1);

  // reset leaves no result and locates the first population before taking requests
  a_reset_state: assert property (@(posedge clk) rst |=> full && empty)
    else $error("reset did not leave full and empty high");

  // a refill of the counters blocks requests while the new sweep is set up
  a_refill_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index == REG_CHANNEL_TOTAL) |=> full)
    else $error("request taken right after a channel_total write");

  // the result counts add up to a legal population of one to MAX_CHANNELS channels
  a_population_kept: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (count_sum >= SW'(1)) && (count_sum <= SW'(MAX_CHANNELS)))
    else $error("result counts do not add up to a legal population");

  // a waiting result holds until it is taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(count_m0h0) && $stable(count_m1h0)
      && $stable(count_m2h0) && $stable(count_m3h0) && $stable(count_m0h1)
      && $stable(count_m1h1) && $stable(count_m2h1) && $stable(count_m3h1))
    else $error("waiting result changed or vanished");

endmodule

bind stochastic_sodium_channel_step ssc_checker #(
  .MAX_CHANNELS (MAX_CHANNELS)
) u_ssc_checker (.*);
